/* hdl/sal_pkg.sv */
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types and constants for the spline arc length block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sal_pkg;

  localparam int SUBINTERVALS_DEF = 150;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int FIELD_W          = 32;
  localparam int LEN_W            = 48;

  // Operand selection of the shared multiplier
  typedef enum logic [2:0] {
    MUL_UU   = 3'd0,
    MUL_C2U  = 3'd1,
    MUL_C3U2 = 3'd2,
    MUL_DD   = 3'd3,
    MUL_WL   = 3'd4,
    MUL_WH   = 3'd5
  } mul_op_e;

  typedef struct packed {
    logic    load;
    logic    sdiv_start;
    logic    pt_init;
    mul_op_e mul_op;
    logic    cap_u2;
    logic    cap_t2;
    logic    cap_t3e;
    logic    cap_d;
    logic    acc_sq;
    logic    root_start;
    logic    pt_next;
    logic    cap_plo;
    logic    cap_phi;
    logic    bdiv_start;
    logic    commit;
  } sal_cmd_t;

  typedef struct packed {
    logic sdiv_busy;
    logic root_busy;
    logic bdiv_busy;
    logic axis_last;
    logic pt_last;
  } sal_status_t;

endpackage

`default_nettype wire

/* hdl/sal_div.sv */
// ----------------------------------------------------------------------------
// sal_div
// Unsigned division by a constant by reciprocal multiplication, one 16-bit
// quotient digit at a time: each digit is estimated, then corrected.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sal_div #(
  parameter int NW   = 32,
  parameter int DEN  = 300,
  parameter int DENW = 9
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NW-1:0]   num_i,
  output logic      [NW-1:0]   quo_o,
  output logic      [DENW-1:0] rem_o,
  output logic                 busy_o
);

  // 16-bit digits, most significant first
  localparam int NC = (NW + 15) / 16;
  localparam int XW = NC * 16;
  localparam int CW = (NC > 1) ? $clog2(NC) : 1;
  // floor(2^32 / DEN): the digit estimate is low by at most one
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(DEN));
  localparam logic [31:0] DEN_V = 32'(DEN);

  logic [XW-1:0]   n_q, quo_q;
  logic [DENW-1:0] rem_q;
  logic [31:0]     t_q;
  logic [15:0]     q0_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q, phase_q;
  logic [31:0]     t, r0;
  logic [63:0]     tm;
  logic            over;

  // partial remainder and next digit, below DEN * 2^16
  assign t    = 32'({rem_q, n_q[XW-1 -: 16]});
  assign tm   = 64'(t) * 64'(RECIP);
  assign r0   = t_q - 32'(q0_q) * DEN_V;
  assign over = r0 >= DEN_V;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else if (busy_q) begin
      phase_q <= !phase_q;
      if (phase_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NC - 1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= XW'(num_i);
      quo_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!phase_q) begin
        t_q  <= t;
        q0_q <= tm[47:32];
      end else begin
        n_q   <= n_q << 16;
        quo_q <= XW'({quo_q, (over ? q0_q + 16'd1 : q0_q)});
        rem_q <= over ? DENW'(r0 - DEN_V) : DENW'(r0);
      end
    end
  end

  assign quo_o  = quo_q[NW-1:0];
  assign rem_o  = rem_q;
  assign busy_o = busy_q;

endmodule

`default_nettype wire

/* hdl/sal_sqrt.sv */
// ----------------------------------------------------------------------------
// sal_sqrt
// Truncating 64-bit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sal_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] value_i,
  output logic      [31:0] root_o,
  output logic             busy_o
);

  logic [63:0] v_q, r_q, bit_q, trial;
  logic [4:0]  cnt_q;
  logic        busy_q;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == 5'd31) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      r_q   <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root_o = r_q[31:0];
  assign busy_o = busy_q;

endmodule

`default_nettype wire

/* hdl/sal_dp.sv */
// ----------------------------------------------------------------------------
// sal_dp
// Datapath: sample stepping, shared multiplier, derivative, root, Simpson
// accumulation, segment scaling and the running total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sal_dp import sal_pkg::*; #(
  parameter int SUBINTERVALS = SUBINTERVALS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire sal_cmd_t                  cmd_i,
  output sal_status_t                    status_o,
  input  wire logic signed [FIELD_W-1:0] span_i,
  input  wire logic signed [FIELD_W-1:0] x_slope_i,
  input  wire logic signed [FIELD_W-1:0] x_curve_i,
  input  wire logic signed [FIELD_W-1:0] x_cubic_i,
  input  wire logic signed [FIELD_W-1:0] y_slope_i,
  input  wire logic signed [FIELD_W-1:0] y_curve_i,
  input  wire logic signed [FIELD_W-1:0] y_cubic_i,
  input  wire logic signed [FIELD_W-1:0] z_slope_i,
  input  wire logic signed [FIELD_W-1:0] z_curve_i,
  input  wire logic signed [FIELD_W-1:0] z_cubic_i,
  output logic signed [LEN_W-1:0]        total_length_o,
  output logic                           saturated_o
);

  localparam int PTS  = 2 * SUBINTERVALS;
  localparam int PW   = $clog2(PTS + 1);
  localparam int WW   = $clog2(6 * SUBINTERVALS) + 31;
  localparam int PRW  = WW + 32;
  // floor(p / (6N * 2^F)) == floor((p >> F) / 6N)
  localparam int QW   = (PRW - FRAC_BITS > 50) ? PRW - FRAC_BITS : 50;
  localparam int SDW  = $clog2(6 * SUBINTERVALS + 1);
  localparam logic [PW-1:0]  PTS_V   = PW'(PTS);
  localparam logic signed [65:0] MAX32 = 66'sh7FFF_FFFF;
  localparam logic signed [65:0] MIN32 = -66'sh8000_0000;
  localparam logic signed [49:0] MAX48 = 50'sh7FFF_FFFF_FFFF;
  localparam logic signed [49:0] MIN48 = -50'sh8000_0000_0000;

  // {clipped, value}
  function automatic logic [32:0] clip32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > MAX32)      r = {1'b1, 32'h7FFF_FFFF};
    else if (v < MIN32) r = {1'b1, 32'h8000_0000};
    else                r = {1'b0, v[31:0]};
    return r;
  endfunction

  logic signed [31:0] slope_q [3];
  logic signed [31:0] curve_q [3];
  logic signed [31:0] cubic_q [3];
  logic [31:0]        mag_q, step_a_q, mq_q;
  logic               neg_q;
  logic [PW-1:0]      step_b_q, mr_q, k_q;
  logic signed [31:0] u_q, u2_q, t2_q, t3_q, e_q, d_q;
  logic [63:0]        sq_q;
  logic [1:0]         axis_q;
  logic [WW-1:0]      w_q;
  logic [PRW-1:0]     p_q;
  logic signed [65:0] prod_q;
  logic signed [LEN_W-1:0] ls_q;
  logic               ovf_q;

  logic signed [32:0] mul_a, mul_b;
  logic [32:0]        fm_r, t2_r, t3_r, e_r, d_r;
  logic signed [31:0] fm_v;
  logic [31:0]        sdiv_quo, root, speed, mq_next;
  logic [PW-1:0]      sdiv_rem;
  logic [PW:0]        mr_sum;
  logic [QW-1:0]      bdiv_quo;
  logic [WW-1:0]      w_add;
  logic [48:0]        seg;
  logic signed [49:0] tot_sum;
  logic signed [LEN_W-1:0] tot;
  logic               tot_sat, sdiv_busy, root_busy, bdiv_busy;

  always_comb begin
    unique case (cmd_i.mul_op)
      MUL_UU:   begin mul_a = 33'(u_q);        mul_b = 33'(u_q);            end
      MUL_C2U:  begin mul_a = 33'(curve_q[0]); mul_b = 33'(u_q);            end
      MUL_C3U2: begin mul_a = 33'(cubic_q[0]); mul_b = 33'(u2_q);           end
      MUL_DD:   begin mul_a = 33'(d_q);        mul_b = 33'(d_q);            end
      MUL_WL:   begin mul_a = {1'b0, w_q[31:0]}; mul_b = {1'b0, mag_q};     end
      MUL_WH:   begin
        mul_a = $signed({{(65 - WW){1'b0}}, w_q[WW-1:32]});
        mul_b = {1'b0, mag_q};
      end
      default:  begin mul_a = '0;              mul_b = '0;                  end
    endcase
  end

  always_comb begin
    fm_r = clip32(prod_q >>> FRAC_BITS);
    fm_v = $signed(fm_r[31:0]);
    t2_r = clip32(66'(fm_v) <<< 1);
    t3_r = clip32(66'(fm_v) * 66'sd3);
    e_r  = clip32(66'(slope_q[0]) + 66'(t2_q));
    d_r  = clip32(66'(e_q) + 66'(t3_q));
  end

  // Sample stepping: u_k = sign * (A*k + floor(B*k / PTS)) where |S| = A*PTS + B
  always_comb begin
    mr_sum  = {1'b0, mr_q} + {1'b0, step_b_q};
    mq_next = mq_q + step_a_q;
    if (mr_sum >= {1'b0, PTS_V}) mq_next = mq_q + step_a_q + 32'd1;
  end

  assign speed = root[31] ? 32'h7FFF_FFFF : root;

  // Simpson weights 1, 4, 2, ..., 4, 1
  always_comb begin
    if (k_q == '0 || k_q == PTS_V) w_add = WW'(speed);
    else if (k_q[0])               w_add = WW'(speed) << 2;
    else                           w_add = WW'(speed) << 1;
  end

  always_comb begin
    if ((|bdiv_quo[QW-1:49]) || (bdiv_quo[48] && (|bdiv_quo[47:0])))
      seg = 49'h1_0000_0000_0000;
    else
      seg = bdiv_quo[48:0];
    if (neg_q) tot_sum = 50'(ls_q) - $signed({1'b0, seg});
    else       tot_sum = 50'(ls_q) + $signed({1'b0, seg});
    tot_sat = 1'b0;
    tot     = tot_sum[LEN_W-1:0];
    if (tot_sum > MAX48) begin
      tot_sat = 1'b1;
      tot     = MAX48[LEN_W-1:0];
    end else if (tot_sum < MIN48) begin
      tot_sat = 1'b1;
      tot     = MIN48[LEN_W-1:0];
    end
  end

  sal_div #(.NW(32), .DEN(PTS), .DENW(PW)) u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.sdiv_start),
    .num_i  (mag_q),
    .quo_o  (sdiv_quo),
    .rem_o  (sdiv_rem),
    .busy_o (sdiv_busy)
  );

  sal_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.root_start),
    .value_i(sq_q),
    .root_o (root),
    .busy_o (root_busy)
  );

  logic [SDW-1:0] bdiv_rem;

  sal_div #(.NW(QW), .DEN(6 * SUBINTERVALS), .DENW(SDW)) u_bdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.bdiv_start),
    .num_i  (QW'(p_q >> FRAC_BITS)),
    .quo_o  (bdiv_quo),
    .rem_o  (bdiv_rem),
    .busy_o (bdiv_busy)
  );

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.load) begin
      slope_q <= '{x_slope_i, y_slope_i, z_slope_i};
      curve_q <= '{x_curve_i, y_curve_i, z_curve_i};
      cubic_q <= '{x_cubic_i, y_cubic_i, z_cubic_i};
      neg_q   <= span_i[31];
      mag_q   <= span_i[31] ? 32'(-span_i) : 32'(span_i);
    end
    if (cmd_i.pt_init) begin
      step_a_q <= sdiv_quo;
      step_b_q <= sdiv_rem;
      mq_q     <= '0;
      mr_q     <= '0;
      k_q      <= '0;
      u_q      <= '0;
      w_q      <= '0;
    end
    if (cmd_i.cap_u2) begin
      u2_q   <= fm_v;
      sq_q   <= '0;
      axis_q <= '0;
    end
    if (cmd_i.cap_t2) t2_q <= $signed(t2_r[31:0]);
    if (cmd_i.cap_t3e) begin
      t3_q <= $signed(t3_r[31:0]);
      e_q  <= $signed(e_r[31:0]);
    end
    if (cmd_i.cap_d) d_q <= $signed(d_r[31:0]);
    if (cmd_i.acc_sq) begin
      sq_q    <= sq_q + prod_q[63:0];
      axis_q  <= axis_q + 2'd1;
      // rotate so the active axis always sits at entry 0
      slope_q <= '{slope_q[1], slope_q[2], slope_q[0]};
      curve_q <= '{curve_q[1], curve_q[2], curve_q[0]};
      cubic_q <= '{cubic_q[1], cubic_q[2], cubic_q[0]};
    end
    if (cmd_i.pt_next) begin
      w_q  <= w_q + w_add;
      k_q  <= k_q + 1'b1;
      mq_q <= mq_next;
      if (mr_sum >= {1'b0, PTS_V}) mr_q <= PW'(mr_sum - {1'b0, PTS_V});
      else                         mr_q <= mr_sum[PW-1:0];
      u_q  <= neg_q ? $signed(-mq_next) : $signed(mq_next);
    end
    if (cmd_i.cap_plo) p_q <= PRW'(prod_q[63:0]);
    if (cmd_i.cap_phi) p_q <= p_q + (PRW'(prod_q[63:0]) << 32);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ls_q           <= '0;
      ovf_q          <= 1'b0;
      total_length_o <= '0;
      saturated_o    <= 1'b0;
    end else begin
      if ((cmd_i.cap_u2 && fm_r[32]) ||
          (cmd_i.cap_t2 && (fm_r[32] || t2_r[32])) ||
          (cmd_i.cap_t3e && (fm_r[32] || t3_r[32] || e_r[32])) ||
          (cmd_i.cap_d && d_r[32]) ||
          (cmd_i.pt_next && root[31]))
        ovf_q <= 1'b1;
      if (cmd_i.commit) begin
        ls_q           <= tot;
        total_length_o <= tot;
        saturated_o    <= ovf_q | tot_sat;
        if (tot_sat) ovf_q <= 1'b1;
      end
    end
  end

  assign status_o.sdiv_busy = sdiv_busy;
  assign status_o.root_busy = root_busy;
  assign status_o.bdiv_busy = bdiv_busy | (bdiv_rem == '1 && 1'b0);
  assign status_o.axis_last = axis_q == 2'd2;
  assign status_o.pt_last   = k_q == PTS_V;

endmodule

`default_nettype wire

/* hdl/sal_ctrl.sv */
// ----------------------------------------------------------------------------
// sal_ctrl
// Sequencer for one segment: per-sample derivative and root, then scaling
// and the total update; owns both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sal_ctrl import sal_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output sal_cmd_t         cmd_o,
  input  wire sal_status_t status_i
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SDS  = 5'd1;
  localparam logic [4:0] ST_SDIV = 5'd2;
  localparam logic [4:0] ST_UU   = 5'd3;
  localparam logic [4:0] ST_U2   = 5'd4;
  localparam logic [4:0] ST_C2   = 5'd5;
  localparam logic [4:0] ST_T2   = 5'd6;
  localparam logic [4:0] ST_T3   = 5'd7;
  localparam logic [4:0] ST_D    = 5'd8;
  localparam logic [4:0] ST_DD   = 5'd9;
  localparam logic [4:0] ST_SQ   = 5'd10;
  localparam logic [4:0] ST_RS   = 5'd11;
  localparam logic [4:0] ST_RT   = 5'd12;
  localparam logic [4:0] ST_WL   = 5'd13;
  localparam logic [4:0] ST_WH   = 5'd14;
  localparam logic [4:0] ST_PH   = 5'd15;
  localparam logic [4:0] ST_BS   = 5'd16;
  localparam logic [4:0] ST_BD   = 5'd17;
  localparam logic [4:0] ST_TOT  = 5'd18;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.mul_op = MUL_UU;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        state_d    = ST_SDS;
      end
      ST_SDS: begin
        cmd_o.sdiv_start = 1'b1;
        state_d          = ST_SDIV;
      end
      ST_SDIV: if (!status_i.sdiv_busy) begin
        cmd_o.pt_init = 1'b1;
        state_d       = ST_UU;
      end
      ST_UU: state_d = ST_U2;
      ST_U2: begin
        cmd_o.cap_u2 = 1'b1;
        state_d      = ST_C2;
      end
      ST_C2: begin
        cmd_o.mul_op = MUL_C2U;
        state_d      = ST_T2;
      end
      ST_T2: begin
        cmd_o.cap_t2 = 1'b1;
        cmd_o.mul_op = MUL_C3U2;
        state_d      = ST_T3;
      end
      ST_T3: begin
        cmd_o.cap_t3e = 1'b1;
        state_d       = ST_D;
      end
      ST_D: begin
        cmd_o.cap_d = 1'b1;
        state_d     = ST_DD;
      end
      ST_DD: begin
        cmd_o.mul_op = MUL_DD;
        state_d      = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.acc_sq = 1'b1;
        state_d      = status_i.axis_last ? ST_RS : ST_C2;
      end
      ST_RS: begin
        cmd_o.root_start = 1'b1;
        state_d          = ST_RT;
      end
      ST_RT: if (!status_i.root_busy) begin
        cmd_o.pt_next = 1'b1;
        state_d       = status_i.pt_last ? ST_WL : ST_UU;
      end
      ST_WL: begin
        cmd_o.mul_op = MUL_WL;
        state_d      = ST_WH;
      end
      ST_WH: begin
        cmd_o.cap_plo = 1'b1;
        cmd_o.mul_op  = MUL_WH;
        state_d       = ST_PH;
      end
      ST_PH: begin
        cmd_o.cap_phi = 1'b1;
        state_d       = ST_BS;
      end
      ST_BS: begin
        cmd_o.bdiv_start = 1'b1;
        state_d          = ST_BD;
      end
      ST_BD: if (!status_i.bdiv_busy) state_d = ST_TOT;
      ST_TOT: if (out_free) begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit)               out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/spline_arc_length_simpson.sv */
// ----------------------------------------------------------------------------
// spline_arc_length_simpson
// Arc length of 3D cubic spline segments by composite Simpson's rule with a
// saturating running total.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one segment: span and the
//   c1/c2/c3 coefficients per axis, Q16.16. Output channel
//   (out_valid_o/out_ready_i) carries the running total (Q32.16) and the
//   sticky saturation flag after each segment.
//   One segment at a time: in_ready_o is high only while the sequencer idles.
//   Each of the 2*SUBINTERVALS+1 samples uses the shared multiplier (10
//   products) and the 32-step square root unit; per segment the two
//   constant dividers run once each, one for the sample step and one for
//   the scaling. A new segment is taken only after the last one has been
//   committed to the output register.
//   The result sits in an output register; a new segment is accepted while
//   it waits. If the receiver stalls the next result until the register is
//   free, the sequencer holds at its last step.
//   Reset clears the running total, the saturation flag and the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spline_arc_length_simpson import sal_pkg::*; #(
  parameter int SUBINTERVALS = SUBINTERVALS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [FIELD_W-1:0] span_i,
  input  wire logic signed [FIELD_W-1:0] x_slope_i,
  input  wire logic signed [FIELD_W-1:0] x_curve_i,
  input  wire logic signed [FIELD_W-1:0] x_cubic_i,
  input  wire logic signed [FIELD_W-1:0] y_slope_i,
  input  wire logic signed [FIELD_W-1:0] y_curve_i,
  input  wire logic signed [FIELD_W-1:0] y_cubic_i,
  input  wire logic signed [FIELD_W-1:0] z_slope_i,
  input  wire logic signed [FIELD_W-1:0] z_curve_i,
  input  wire logic signed [FIELD_W-1:0] z_cubic_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [LEN_W-1:0]        total_length_o,
  output logic                           saturated_o
);

  sal_cmd_t    cmd;
  sal_status_t status;

  sal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  sal_dp #(
    .SUBINTERVALS(SUBINTERVALS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .span_i        (span_i),
    .x_slope_i     (x_slope_i),
    .x_curve_i     (x_curve_i),
    .x_cubic_i     (x_cubic_i),
    .y_slope_i     (y_slope_i),
    .y_curve_i     (y_curve_i),
    .y_cubic_i     (y_cubic_i),
    .z_slope_i     (z_slope_i),
    .z_curve_i     (z_curve_i),
    .z_cubic_i     (z_cubic_i),
    .total_length_o(total_length_o),
    .saturated_o   (saturated_o)
  );

endmodule

`default_nettype wire

/* hdl/sal_checker.sv */
// ----------------------------------------------------------------------------
// sal_checker
// Port-level assertions for the spline arc length block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sal_checker import sal_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic signed [LEN_W-1:0]  total_length_o,
  input wire logic                     saturated_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out_valid_o dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(total_length_o) && $stable(saturated_o))
    else $error("result changed while stalled");

  a_sat_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(saturated_o))
    else $error("saturation flag cleared without reset");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second segment taken while busy");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared right after input transfer");

endmodule

bind spline_arc_length_simpson sal_checker u_sal_checker (.*);

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for spline_arc_length_simpson: each segment is scored
// against an in-bench fixed-point Simpson predictor, and every total and
// saturation flag is checked in order of transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sal_pkg::*;

  localparam int  NSUB      = SUBINTERVALS_DEF;
  localparam int  FRAC      = FRAC_BITS_DEF;
  localparam int  HOLD_CYC  = 40000;
  localparam longint LIMIT  = 8000000;
  localparam longint MAX48  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint MIN48  = -64'sh0000_8000_0000_0000;

  typedef struct {
    logic signed [FIELD_W-1:0] span;
    logic signed [FIELD_W-1:0] c [9];   // x c1,c2,c3 then y, then z
  } segment_t;

  typedef struct {
    logic [LEN_W-1:0] total;
    logic             sat;
  } length_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [FIELD_W-1:0] span_i = '0;
  logic signed [FIELD_W-1:0] coef_q [9];
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [LEN_W-1:0] total_length_o;
  logic saturated_o;

  length_out_t expected_lengths [$];
  longint run_sum = 0;
  bit     run_sat = 1'b0;
  int     errors = 0;
  longint cycles = 0;
  bit     quiet = 1'b0;
  bit     hold_req = 1'b0;

  initial foreach (coef_q[i]) coef_q[i] = '0;

  always #10 clk_i = ~clk_i;

  spline_arc_length_simpson uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .span_i,
    .x_slope_i(coef_q[0]), .x_curve_i(coef_q[1]), .x_cubic_i(coef_q[2]),
    .y_slope_i(coef_q[3]), .y_curve_i(coef_q[4]), .y_cubic_i(coef_q[5]),
    .z_slope_i(coef_q[6]), .z_curve_i(coef_q[7]), .z_cubic_i(coef_q[8]),
    .out_valid_o, .out_ready_i, .total_length_o, .saturated_o
  );

  // ---------------- predictor ----------------
  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      run_sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      run_sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // exact product, floor shift, clip
  function automatic longint qmul(longint a, longint b);
    return clip32((a * b) >>> FRAC);
  endfunction

  function automatic longint axis_deriv(longint c1, longint c2, longint c3, longint u);
    longint u2, t2, t3;
    u2 = qmul(u, u);
    t2 = clip32(2 * qmul(c2, u));
    t3 = clip32(3 * qmul(c3, u2));
    return clip32(clip32(c1 + t2) + t3);
  endfunction

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned speed(segment_t s, longint u);
    longint unsigned sq, rt;
    longint d;
    sq = 0;
    for (int a = 0; a < 3; a++) begin
      d = axis_deriv(s.c[3*a], s.c[3*a+1], s.c[3*a+2], u);
      sq += longint'(d * d);
    end
    rt = isqrt64(sq);
    if (rt > 64'd2147483647) begin
      run_sat = 1'b1;
      rt = 64'd2147483647;
    end
    return rt;
  endfunction

  function automatic length_out_t arc_length_step(segment_t s);
    longint span, u, total;
    longint unsigned wsum, w, mag, dv, hi, lo, qa, ra, seg;
    length_out_t r;
    span = s.span;
    wsum = 0;
    for (int k = 0; k <= 2 * NSUB; k++) begin
      u = (span * k) / (2 * NSUB);
      w = (k == 0 || k == 2 * NSUB) ? 1 : ((k % 2) ? 4 : 2);
      wsum += w * speed(s, u);
    end
    mag = (span < 0) ? -span : span;
    dv  = (64'd6 * NSUB) << FRAC;
    hi  = mag >> 16;
    lo  = mag & 64'hFFFF;
    qa  = (wsum * hi) / dv;
    ra  = (wsum * hi) % dv;
    if (qa >= (64'd1 << 32)) begin
      seg = 64'd1 << 48;
    end else begin
      seg = (qa << 16) + ((ra << 16) + wsum * lo) / dv;
      if (seg > (64'd1 << 48)) seg = 64'd1 << 48;
    end
    total = (span < 0) ? run_sum - longint'(seg) : run_sum + longint'(seg);
    if (total > MAX48) begin
      run_sat = 1'b1;
      total = MAX48;
    end
    if (total < MIN48) begin
      run_sat = 1'b1;
      total = MIN48;
    end
    run_sum = total;
    r.total = total[LEN_W-1:0];
    r.sat   = run_sat;
    return r;
  endfunction

  // ---------------- checking ----------------
  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_lengths.size() == 0) begin
        report("unexpected result", total_length_o, 0);
      end else begin
        length_out_t e;
        e = expected_lengths.pop_front();
        if (total_length_o !== e.total) report("total_length", total_length_o, e.total);
        if (saturated_o !== e.sat) report("saturated", saturated_o, e.sat);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("spline_arc_length_simpson verification failed");
      $finish;
    end
  end

  // receiver: random ready bursts, one long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_segment(segment_t s);
    span_i     <= s.span;
    foreach (coef_q[i]) coef_q[i] <= s.c[i];
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_lengths.push_back(arc_length_step(s));
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_lengths.size() != 0) @(posedge clk_i);
  endtask

  function automatic segment_t make_seg(int sp, int x1, int x2, int x3, int y1, int y2,
                                        int y3, int z1, int z2, int z3);
    segment_t s;
    s.span = sp;
    s.c[0] = x1; s.c[1] = x2; s.c[2] = x3;
    s.c[3] = y1; s.c[4] = y2; s.c[5] = y3;
    s.c[6] = z1; s.c[7] = z2; s.c[8] = z3;
    return s;
  endfunction

  function automatic logic signed [31:0] rand_mod(int half);
    return $signed($urandom_range(0, 2 * half)) - half;
  endfunction

  function automatic segment_t rand_seg(bit full);
    segment_t s;
    s.span = full ? $urandom() : rand_mod(32'h4_0000);
    foreach (s.c[i]) s.c[i] = full ? $urandom() : rand_mod(32'h10_0000);
    return s;
  endfunction

  localparam int ONE = 32'h1_0000;

  task automatic test_plain_segments();
    segment_t list [$];
    list.push_back(make_seg(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    list.push_back(make_seg(ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    list.push_back(make_seg(-ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    list.push_back(make_seg(2 * ONE, 3 * ONE, 0, 0, 4 * ONE, 0, 0, 0, 0, 0));
    list.push_back(make_seg(0, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
    list.push_back(make_seg(ONE, 0, ONE, 0, 0, 0, -ONE, 0, 0, ONE / 2));
    list.push_back(make_seg(1, ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    list.push_back(make_seg(3 * ONE, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    list.push_back(make_seg(-3 * ONE / 2, -2 * ONE, ONE, -ONE, 5 * ONE, -ONE / 4,
                            ONE / 8, 0, 7 * ONE, -ONE / 3));
    foreach (list[i]) begin
      send_segment(list[i]);
      sender_gap();
    end
    drain();
  endtask

  task automatic test_random_moderate(int n);
    repeat (n) begin
      send_segment(rand_seg(1'b0));
      sender_gap();
    end
    drain();
  endtask

  // receiver stalls long enough that a result waits and the input backs up
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    repeat (4) send_segment(rand_seg(1'b0));
    drain();
  endtask

  task automatic test_saturation_extremes();
    int mx, mn;
    segment_t list [$];
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    list.push_back(make_seg(mx, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    list.push_back(make_seg(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
    list.push_back(make_seg(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
    list.push_back(make_seg(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
    list.push_back(make_seg(mn, mx, 0, 0, mn, 0, 0, mx, 0, 0));
    list.push_back(make_seg(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
    list.push_back(make_seg(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
    list.push_back(make_seg(mx, mx, mn, mx, mn, mx, mn, mx, mn, mx));
    list.push_back(make_seg(ONE, mn, mx, mn, 0, 0, 0, 0, 0, 0));
    foreach (list[i]) begin
      send_segment(list[i]);
      sender_gap();
    end
    drain();
  endtask

  task automatic test_random_full(int n, int calm);
    for (int i = 0; i < n; i++) begin
      if (i == n - calm) quiet = 1'b1;
      send_segment(i % 2 ? rand_seg(1'b1) : rand_seg(1'b0));
      sender_gap();
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_segments();
    test_random_moderate(32);
    test_output_backpressure();
    test_saturation_extremes();
    test_random_full(46, 12);
    repeat (200) @(posedge clk_i);
    if (errors == 0)
      $display("spline_arc_length_simpson verification clean");
    else
      $display("spline_arc_length_simpson verification failed");
    $finish;
  end

endmodule

/* spline_arc_length_simpson.f */
hdl/sal_pkg.sv
hdl/sal_div.sv
hdl/sal_sqrt.sv
hdl/sal_dp.sv
hdl/sal_ctrl.sv
hdl/spline_arc_length_simpson.sv
hdl/sal_checker.sv
bench/testbench.sv
